// ===== design/svgrip_pkg.sv =====
package svgrip_pkg;

   localparam int unsigned NUM_SLOTS = 3;

   typedef enum logic [1:0] {
      MODE_TICK = 2'd0,
      MODE_MOVE = 2'd1,
      MODE_GRIP = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      CHAN_SHOULDER = 2'd0,
      CHAN_WRIST    = 2'd1,
      CHAN_GRIPPER  = 2'd2
   } chan_type;

   typedef enum logic [1:0] {
      CSR_SHOULDER_TRIM = 2'd0,
      CSR_WRIST_TRIM    = 2'd1,
      CSR_GRIP_OFFSET   = 2'd2,
      CSR_GRIP_DURATION = 2'd3
   } csr_index_type;

   localparam logic [7:0]         MAX_ANGLE      = 8'd180;
   localparam logic [7:0]         HOME_ANGLE     = 8'd90;
   localparam logic [15:0]        RESET_INTERVAL = 16'd30;
   localparam logic [15:0]        RESET_DURATION = 16'd800;
   localparam logic [15:0]        SAT16          = 16'hFFFF;
   localparam logic signed [12:0] CENTER_US      = 13'sd1500;
   localparam logic signed [12:0] CLOSE_US       = 13'sd1800;
   localparam logic signed [12:0] OPEN_US        = 13'sd1200;
   // floor(us * 4096 / 20000) == (us * TICK_RECIP) >> 24 for every us below 4096.
   localparam logic [21:0]        TICK_RECIP     = 22'd3435974;
   localparam logic [11:0]        NEUTRAL_TICKS  = 12'(1500 * 4096 / 20000);

   typedef logic [10:0] angle_us_table_type [0:255];

   function automatic angle_us_table_type build_angle_us();
      angle_us_table_type t;
      for (int a = 0; a < 256; a++) begin
         t[a] = 11'(((a > 180) ? 180 : a) * 1000 / 180 + 1000);
      end
      return t;
   endfunction

   localparam angle_us_table_type ANGLE_US_TABLE = build_angle_us();

   function automatic logic [10:0] angle_us(input logic [7:0] a);
      return ANGLE_US_TABLE[a];
   endfunction

   function automatic logic [11:0] us_to_ticks(input logic signed [12:0] us);
      logic [33:0] prod;
      prod = {22'd0, us[11:0]} * {12'd0, TICK_RECIP};
      if (us < 0) begin
         return 12'd0;
      end
      return {2'b00, prod[33:24]};
   endfunction

   function automatic logic [7:0] clamp_angle(input logic [7:0] a);
      return (a > MAX_ANGLE) ? MAX_ANGLE : a;
   endfunction

   typedef struct packed {
      chan_type   channel;
      logic [11:0] ticks;
   } entry_type;

   typedef struct packed {
      entry_type [NUM_SLOTS-1:0] entry;
      logic [1:0]                count;
   } bundle_type;

endpackage

// ===== design/svgrip_if.sv =====
interface svgrip_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [7:0]  target_shoulder;
   logic [7:0]  target_wrist;
   logic [15:0] step_interval;
   logic        grip_close;

   modport source(output valid, mode, target_shoulder, target_wrist, step_interval,
                  grip_close, input ready);
   modport sink(input valid, mode, target_shoulder, target_wrist, step_interval,
                grip_close, output ready);
endinterface

interface svgrip_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  channel;
   logic [11:0] pulse_ticks;
   logic        last;

   modport source(output valid, channel, pulse_ticks, last, input ready);
   modport sink(input valid, channel, pulse_ticks, last, output ready);
endinterface

interface svgrip_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;

   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

// ===== design/svgrip_serializer.sv =====
module svgrip_serializer
   import svgrip_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  bundle_type bundle,
   output logic       free,
   svgrip_rsp_if.source rsp
);

   bundle_type bundle_ff;
   logic [1:0] count_ff, count_in;
   logic [1:0] ptr_ff, ptr_in;
   logic       last_now;
   logic       take;

   assign last_now    = (ptr_ff == count_ff - 2'd1);
   assign take        = rsp.valid && rsp.ready;
   assign rsp.valid   = (count_ff != 2'd0);
   assign rsp.channel = bundle_ff.entry[ptr_ff].channel;
   assign rsp.pulse_ticks = bundle_ff.entry[ptr_ff].ticks;
   assign rsp.last    = last_now;

   // The bundle frees up in the same cycle its final item leaves.
   assign free = (count_ff == 2'd0) || (rsp.ready && last_now);

   always_comb begin
      count_in = count_ff;
      ptr_in   = ptr_ff;
      if (load) begin
         count_in = bundle.count;
         ptr_in   = 2'd0;
      end else if (take) begin
         if (last_now) begin
            count_in = 2'd0;
            ptr_in   = 2'd0;
         end else begin
            ptr_in = ptr_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         ptr_ff   <= 2'd0;
      end else begin
         count_ff <= count_in;
         ptr_ff   <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         bundle_ff <= bundle;
      end
   end

endmodule

// ===== design/servo_slew_and_gripper_pulse.sv =====
// Channel  Dir  Handshake     Payload
// req_ch   in   valid/ready   mode, target_shoulder, target_wrist, step_interval, grip_close
// rsp_ch   out  valid/ready   channel, pulse_ticks, last
// csr_ch   in   valid/ready   index, data (always ready)
//
// An item is registered on acceptance and processed once the result bundle is
// free; it then yields zero to three results, one per cycle while rsp_ch is ready.
// A tick that moves both joints and releases the gripper yields three results,
// which leave in turn through the single result port; the next item is
// processed in the cycle the last of them leaves.
// Reset is synchronous and restores home angles and default registers.
// A stalled rsp_ch holds one waiting item in the input register.
module servo_slew_and_gripper_pulse
   import svgrip_pkg::*;
(
   input logic clock,
   input logic reset,
   svgrip_req_if.sink   req_ch,
   svgrip_rsp_if.source rsp_ch,
   svgrip_csr_if.sink   csr_ch
);

   // Configuration registers.
   logic [7:0]  sh_trim_ff;
   logic [7:0]  wr_trim_ff;
   logic [9:0]  grip_offset_ff;
   logic [15:0] grip_duration_ff;

   // Block state.
   logic [7:0]  sh_angle_ff, sh_angle_in;
   logic [7:0]  sh_goal_ff, sh_goal_in;
   logic [7:0]  wr_angle_ff, wr_angle_in;
   logic [7:0]  wr_goal_ff, wr_goal_in;
   logic [15:0] interval_ff, interval_in;
   logic [15:0] move_elapsed_ff, move_elapsed_in;
   logic        grip_busy_ff, grip_busy_in;
   logic [15:0] grip_elapsed_ff, grip_elapsed_in;

   // Input register.
   logic        in_valid_ff, in_valid_in;
   logic [1:0]  in_mode_ff;
   logic [7:0]  in_sh_ff;
   logic [7:0]  in_wr_ff;
   logic [15:0] in_interval_ff;
   logic        in_close_ff;

   logic        free;
   logic        process;
   bundle_type  bundle;

   logic [15:0] move_inc;
   logic [15:0] grip_inc;
   logic        step_due;
   logic [7:0]  sh_step;
   logic [7:0]  wr_step;
   logic        sh_moved;
   logic        wr_moved;
   logic        grip_done;
   logic signed [12:0] sh_us;
   logic signed [12:0] wr_us;
   logic signed [12:0] grip_us;
   logic [11:0] grip_ticks;
   logic [NUM_SLOTS-1:0] cand_valid;
   entry_type   [NUM_SLOTS-1:0] cand;
   logic [1:0]  fill;

   assign csr_ch.ready = 1'b1;
   assign process      = in_valid_ff && free;
   assign req_ch.ready = !in_valid_ff || free;

   always_ff @(posedge clock) begin
      if (reset) begin
         sh_trim_ff       <= HOME_ANGLE;
         wr_trim_ff       <= HOME_ANGLE;
         grip_offset_ff   <= 10'd0;
         grip_duration_ff <= RESET_DURATION;
      end else if (csr_ch.valid) begin
         case (csr_index_type'(csr_ch.index))
            CSR_SHOULDER_TRIM: sh_trim_ff       <= clamp_angle(csr_ch.data[7:0]);
            CSR_WRIST_TRIM:    wr_trim_ff       <= clamp_angle(csr_ch.data[7:0]);
            CSR_GRIP_OFFSET:   grip_offset_ff   <= csr_ch.data[9:0];
            CSR_GRIP_DURATION: grip_duration_ff <= csr_ch.data;
            default: begin
            end
         endcase
      end
   end

   assign in_valid_in = (req_ch.valid && req_ch.ready) || (in_valid_ff && !process);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_mode_ff     <= req_ch.mode;
         in_sh_ff       <= req_ch.target_shoulder;
         in_wr_ff       <= req_ch.target_wrist;
         in_interval_ff <= req_ch.step_interval;
         in_close_ff    <= req_ch.grip_close;
      end
   end

   // Tick arithmetic: saturating counters and one-degree steps.
   assign move_inc = (move_elapsed_ff == SAT16) ? SAT16 : move_elapsed_ff + 16'd1;
   assign grip_inc = (grip_elapsed_ff == SAT16) ? SAT16 : grip_elapsed_ff + 16'd1;
   assign step_due = (move_inc >= interval_ff);
   assign sh_moved = (sh_angle_ff != sh_goal_ff);
   assign wr_moved = (wr_angle_ff != wr_goal_ff);
   assign sh_step  = (sh_angle_ff < sh_goal_ff) ? sh_angle_ff + 8'd1 :
                     (sh_angle_ff > sh_goal_ff) ? sh_angle_ff - 8'd1 : sh_angle_ff;
   assign wr_step  = (wr_angle_ff < wr_goal_ff) ? wr_angle_ff + 8'd1 :
                     (wr_angle_ff > wr_goal_ff) ? wr_angle_ff - 8'd1 : wr_angle_ff;
   assign grip_done = grip_busy_ff && (grip_inc >= grip_duration_ff);

   // Pulse widths in microseconds; the trim is the trim angle's width less center.
   assign sh_us = $signed({2'b00, angle_us(sh_step)}) +
                  $signed({2'b00, angle_us(sh_trim_ff)}) - CENTER_US;
   assign wr_us = $signed({2'b00, angle_us(wr_step)}) +
                  $signed({2'b00, angle_us(wr_trim_ff)}) - CENTER_US;
   assign grip_us = (in_close_ff ? CLOSE_US : OPEN_US) +
                    $signed({{3{grip_offset_ff[9]}}, grip_offset_ff});
   assign grip_ticks = (mode_type'(in_mode_ff) == MODE_TICK) ? NEUTRAL_TICKS :
                       us_to_ticks(grip_us);

   always_comb begin
      cand[0].channel = CHAN_SHOULDER;
      cand[0].ticks   = us_to_ticks(sh_us);
      cand[1].channel = CHAN_WRIST;
      cand[1].ticks   = us_to_ticks(wr_us);
      cand[2].channel = CHAN_GRIPPER;
      cand[2].ticks   = grip_ticks;
      cand_valid      = '0;
      case (mode_type'(in_mode_ff))
         MODE_TICK: begin
            cand_valid[0] = step_due && sh_moved;
            cand_valid[1] = step_due && wr_moved;
            cand_valid[2] = grip_done;
         end
         MODE_GRIP: begin
            cand_valid[2] = !grip_busy_ff;
         end
         default: begin
         end
      endcase
   end

   // Pack the valid results to the front of the bundle, shoulder first.
   always_comb begin
      fill         = 2'd0;
      bundle.entry = cand;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (cand_valid[i]) begin
            bundle.entry[fill] = cand[i];
            fill = fill + 2'd1;
         end
      end
      bundle.count = fill;
   end

   always_comb begin
      sh_angle_in     = sh_angle_ff;
      sh_goal_in      = sh_goal_ff;
      wr_angle_in     = wr_angle_ff;
      wr_goal_in      = wr_goal_ff;
      interval_in     = interval_ff;
      move_elapsed_in = move_elapsed_ff;
      grip_busy_in    = grip_busy_ff;
      grip_elapsed_in = grip_elapsed_ff;
      if (process) begin
         case (mode_type'(in_mode_ff))
            MODE_TICK: begin
               move_elapsed_in = move_inc;
               grip_elapsed_in = grip_inc;
               if (step_due) begin
                  move_elapsed_in = 16'd0;
                  sh_angle_in     = sh_step;
                  wr_angle_in     = wr_step;
               end
               if (grip_done) begin
                  grip_busy_in = 1'b0;
               end
            end
            MODE_MOVE: begin
               sh_goal_in  = clamp_angle(in_sh_ff);
               wr_goal_in  = clamp_angle(in_wr_ff);
               interval_in = in_interval_ff;
            end
            MODE_GRIP: begin
               if (!grip_busy_ff) begin
                  grip_elapsed_in = 16'd0;
                  grip_busy_in    = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sh_angle_ff     <= HOME_ANGLE;
         sh_goal_ff      <= HOME_ANGLE;
         wr_angle_ff     <= HOME_ANGLE;
         wr_goal_ff      <= HOME_ANGLE;
         interval_ff     <= RESET_INTERVAL;
         move_elapsed_ff <= 16'd0;
         grip_busy_ff    <= 1'b0;
         grip_elapsed_ff <= 16'd0;
      end else begin
         sh_angle_ff     <= sh_angle_in;
         sh_goal_ff      <= sh_goal_in;
         wr_angle_ff     <= wr_angle_in;
         wr_goal_ff      <= wr_goal_in;
         interval_ff     <= interval_in;
         move_elapsed_ff <= move_elapsed_in;
         grip_busy_ff    <= grip_busy_in;
         grip_elapsed_ff <= grip_elapsed_in;
      end
   end

   svgrip_serializer u_serializer (
      .clock  (clock),
      .reset  (reset),
      .load   (process),
      .bundle (bundle),
      .free   (free),
      .rsp    (rsp_ch)
   );

endmodule

// ===== tb/servo_pulse_check_pkg.sv =====
package servo_pulse_check_pkg;
   import svgrip_pkg::*;

   // Mode value with no meaning; the block must drop such an item.
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [1:0]  mode;
      logic [7:0]  target_shoulder;
      logic [7:0]  target_wrist;
      logic [15:0] step_interval;
      logic        grip_close;
   } servo_cmd_type;

   typedef struct packed {
      logic [1:0]  channel;
      logic [11:0] ticks;
      logic        last;
   } pulse_type;

   class pulse_tracker;
      pulse_type   expected_pulses[$];
      logic [7:0]  shoulder_trim;
      logic [7:0]  wrist_trim;
      int          grip_offset;
      logic [15:0] grip_hold;
      logic [7:0]  shoulder_now;
      logic [7:0]  shoulder_goal;
      logic [7:0]  wrist_now;
      logic [7:0]  wrist_goal;
      logic [15:0] step_every;
      logic [15:0] step_count;
      logic [15:0] grip_count;
      bit          grip_busy;
      int          items_seen;
      int          pulses_seen;
      int          mismatches;
      int          reg_writes;

      function new();
         shoulder_trim = HOME_ANGLE;
         wrist_trim    = HOME_ANGLE;
         grip_offset   = 0;
         grip_hold     = RESET_DURATION;
         shoulder_now  = HOME_ANGLE;
         shoulder_goal = HOME_ANGLE;
         wrist_now     = HOME_ANGLE;
         wrist_goal    = HOME_ANGLE;
         step_every    = RESET_INTERVAL;
         step_count    = '0;
         grip_count    = '0;
         grip_busy     = 1'b0;
         items_seen    = 0;
         pulses_seen   = 0;
         mismatches    = 0;
         reg_writes    = 0;
      endfunction

      static function logic [7:0] limit_angle(logic [7:0] a);
         return (a > MAX_ANGLE) ? MAX_ANGLE : a;
      endfunction

      static function int angle_micros(logic [7:0] a);
         return int'(a) * 1000 / 180 + 1000;
      endfunction

      static function logic [11:0] micros_to_count(int us);
         if (us < 0) return 12'd0;
         return 12'(us * 4096 / 20000);
      endfunction

      static function logic [7:0] step_toward(logic [7:0] cur, logic [7:0] goal);
         if (cur < goal) return cur + 8'd1;
         if (cur > goal) return cur - 8'd1;
         return cur;
      endfunction

      // The trim is the offset of the trim angle's pulse width from center.
      static function logic [11:0] joint_count(logic [7:0] angle, logic [7:0] trim);
         return micros_to_count(angle_micros(angle) + angle_micros(trim) - int'(CENTER_US));
      endfunction

      function void write_reg(csr_index_type idx, logic [15:0] data);
         case (idx)
            CSR_SHOULDER_TRIM: shoulder_trim = limit_angle(data[7:0]);
            CSR_WRIST_TRIM:    wrist_trim = limit_angle(data[7:0]);
            CSR_GRIP_OFFSET:   grip_offset = int'($signed(data[9:0]));
            CSR_GRIP_DURATION: grip_hold = data;
            default: ;
         endcase
         reg_writes++;
      endfunction

      function void note_command(servo_cmd_type c);
         pulse_type  batch[$];
         logic [7:0] stepped;
         int         us;
         items_seen++;
         case (c.mode)
            MODE_TICK: begin
               if (step_count != SAT16) step_count++;
               if (grip_count != SAT16) grip_count++;
               if (step_count >= step_every) begin
                  step_count = '0;
                  stepped = step_toward(shoulder_now, shoulder_goal);
                  if (stepped != shoulder_now) begin
                     shoulder_now = stepped;
                     batch.push_back('{channel: CHAN_SHOULDER, last: 1'b0,
                                       ticks: joint_count(shoulder_now, shoulder_trim)});
                  end
                  stepped = step_toward(wrist_now, wrist_goal);
                  if (stepped != wrist_now) begin
                     wrist_now = stepped;
                     batch.push_back('{channel: CHAN_WRIST, last: 1'b0,
                                       ticks: joint_count(wrist_now, wrist_trim)});
                  end
               end
               if (grip_busy && grip_count >= grip_hold) begin
                  batch.push_back('{channel: CHAN_GRIPPER, last: 1'b0,
                                    ticks: micros_to_count(int'(CENTER_US))});
                  grip_busy = 1'b0;
               end
            end
            MODE_MOVE: begin
               shoulder_goal = limit_angle(c.target_shoulder);
               wrist_goal    = limit_angle(c.target_wrist);
               step_every    = c.step_interval;
            end
            MODE_GRIP: begin
               if (!grip_busy) begin
                  us = (c.grip_close ? int'(CLOSE_US) : int'(OPEN_US)) + grip_offset;
                  batch.push_back('{channel: CHAN_GRIPPER, last: 1'b0,
                                    ticks: micros_to_count(us)});
                  grip_count = '0;
                  grip_busy  = 1'b1;
               end
            end
            default: ;
         endcase
         if (batch.size() != 0) batch[batch.size() - 1].last = 1'b1;
         foreach (batch[i]) expected_pulses.push_back(batch[i]);
      endfunction

      function void check_pulse(logic [1:0] channel, logic [11:0] ticks, logic last);
         pulse_type want;
         pulses_seen++;
         if (expected_pulses.size() == 0) begin
            if (mismatches < REPORT_LIMIT)
               $display("Unexpected result: channel %0d ticks %0d last %0d",
                        channel, ticks, last);
            mismatches++;
            return;
         end
         want = expected_pulses.pop_front();
         if (channel !== want.channel || ticks !== want.ticks || last !== want.last) begin
            if (mismatches < REPORT_LIMIT)
               $display("Result %0d wrong: expected channel %0d ticks %0d last %0d, got %0d %0d %0d",
                        pulses_seen, want.channel, want.ticks, want.last, channel, ticks, last);
            mismatches++;
         end
      endfunction
   endclass

endpackage

// ===== tb/testbench.sv =====
module testbench;
   import svgrip_pkg::*;
   import servo_pulse_check_pkg::*;

   logic clock;
   logic reset;
   bit   req_idling;
   bit   rsp_idling;
   bit   hold_request;
   int   hold_left;
   int   idle_left;
   int   input_stalls;

   pulse_tracker tracker = new();

   svgrip_req_if req_ch();
   svgrip_rsp_if rsp_ch();
   svgrip_csr_if csr_ch();

   servo_slew_and_gripper_pulse DUT (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_ch(csr_ch)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   initial begin
      #4000000;
      $display("Timed out waiting for the block");
      $display("Test completed with failures");
      $finish;
   end

   // Result side: checks each accepted item, counts input stalls, then decides ready for the next cycle.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            tracker.check_pulse(rsp_ch.channel, rsp_ch.pulse_ticks, rsp_ch.last);
         if (!reset && req_ch.valid === 1'b1 && req_ch.ready !== 1'b1) input_stalls++;
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = 120;
         end
         if (hold_left != 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else if (idle_left != 0) begin
            rsp_ch.ready <= 1'b0;
            idle_left--;
         end else if (rsp_idling && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready <= 1'b0;
            idle_left = $urandom_range(0, 7);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   task automatic put_item(input servo_cmd_type c);
      if (req_idling && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_ch.valid           <= 1'b1;
      req_ch.mode            <= c.mode;
      req_ch.target_shoulder <= c.target_shoulder;
      req_ch.target_wrist    <= c.target_wrist;
      req_ch.step_interval   <= c.step_interval;
      req_ch.grip_close      <= c.grip_close;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      tracker.note_command(c);
   endtask

   task automatic send(logic [1:0] mode, logic [7:0] shoulder, logic [7:0] wrist,
                       logic [15:0] interval, logic close);
      servo_cmd_type c;
      c = '{mode: mode, target_shoulder: shoulder, target_wrist: wrist,
            step_interval: interval, grip_close: close};
      put_item(c);
   endtask

   task automatic tick_n(int count);
      repeat (count) send(MODE_TICK, 8'($urandom), 8'($urandom), 16'($urandom), 1'($urandom));
   endtask

   // Unused upper data bits carry noise; the block must ignore them.
   task automatic program_regs(logic [7:0] s_trim, logic [7:0] w_trim,
                               logic [9:0] offset, logic [15:0] hold);
      csr_index_type idx;
      logic [15:0]   data;
      for (int i = 0; i < 4; i++) begin
         idx = csr_index_type'(i);
         case (idx)
            CSR_SHOULDER_TRIM: data = {8'($urandom), s_trim};
            CSR_WRIST_TRIM:    data = {8'($urandom), w_trim};
            CSR_GRIP_OFFSET:   data = {6'($urandom), offset};
            CSR_GRIP_DURATION: data = hold;
            default:           data = '0;
         endcase
         csr_ch.valid <= 1'b1;
         csr_ch.index <= idx;
         csr_ch.data  <= data;
         do @(posedge clock); while (csr_ch.ready !== 1'b1);
         tracker.write_reg(idx, data);
      end
      csr_ch.valid <= 1'b0;
   endtask

   // Items that produce nothing may still be in flight when the queue empties.
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (tracker.expected_pulses.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_angle();
      case ($urandom_range(0, 9))
         0:       return 8'd0;
         1:       return MAX_ANGLE;
         2:       return 8'($urandom_range(181, 255));
         default: return 8'($urandom_range(0, 180));
      endcase
   endfunction

   function automatic logic [9:0] pick_offset();
      case ($urandom_range(0, 5))
         0:       return 10'h200;
         1:       return 10'h1FF;
         2:       return 10'(-500);
         3:       return 10'd500;
         default: return 10'($urandom);
      endcase
   endfunction

   task automatic random_setup();
      program_regs(pick_angle(), pick_angle(), pick_offset(),
                   ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 40)));
   endtask

   function automatic servo_cmd_type random_cmd();
      servo_cmd_type c;
      int            r;
      r = $urandom_range(0, 99);
      c.mode = (r < 64) ? MODE_TICK : (r < 80) ? MODE_MOVE : (r < 96) ? MODE_GRIP : MODE_UNUSED;
      c.target_shoulder = pick_angle();
      c.target_wrist    = pick_angle();
      c.step_interval   = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                       : 16'($urandom_range(0, 4));
      c.grip_close      = 1'($urandom);
      return c;
   endfunction

   task automatic run_random(int count);
      repeat (count) put_item(random_cmd());
   endtask

   // Drive both joints far from their goals, then block the result side so the
   // block backs up and has to refuse input.
   task automatic squeeze();
      req_idling = 1'b0;
      send(MODE_MOVE, (tracker.shoulder_now < HOME_ANGLE) ? MAX_ANGLE : 8'd0,
           (tracker.wrist_now < HOME_ANGLE) ? MAX_ANGLE : 8'd0, 16'd0, 1'($urandom));
      hold_request = 1'b1;
      tick_n(24);
      req_idling = 1'b1;
   endtask

   initial begin
      reset                  = 1'b1;
      req_ch.valid           = 1'b0;
      req_ch.mode            = MODE_TICK;
      req_ch.target_shoulder = '0;
      req_ch.target_wrist    = '0;
      req_ch.step_interval   = '0;
      req_ch.grip_close      = 1'b0;
      csr_ch.valid           = 1'b0;
      csr_ch.index           = CSR_SHOULDER_TRIM;
      csr_ch.data            = '0;
      req_idling             = 1'b1;
      rsp_idling             = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Registers at their reset values; second gripper item lands while busy.
      send(MODE_GRIP, 8'($urandom), 8'($urandom), 16'($urandom), 1'b1);
      send(MODE_GRIP, 8'($urandom), 8'($urandom), 16'($urandom), 1'b0);
      send(MODE_UNUSED, 8'($urandom), 8'($urandom), 16'($urandom), 1'($urandom));
      send(MODE_MOVE, 8'd255, 8'd0, 16'd0, 1'($urandom));
      tick_n(2);
      settle();

      // Zero hold time releases the pending gripper on the very next tick.
      program_regs(8'd0, 8'd255, 10'h200, 16'd0);
      tick_n(1);
      send(MODE_GRIP, 8'($urandom), 8'($urandom), 16'($urandom), 1'b0);
      tick_n(1);
      send(MODE_GRIP, 8'($urandom), 8'($urandom), 16'($urandom), 1'b1);
      send(MODE_MOVE, HOME_ANGLE, HOME_ANGLE, 16'hFFFF, 1'($urandom));
      tick_n(1);
      send(MODE_MOVE, MAX_ANGLE, MAX_ANGLE, 16'd1, 1'($urandom));
      tick_n(4);
      settle();

      program_regs(MAX_ANGLE, 8'd0, 10'h1FF, 16'd3);
      send(MODE_GRIP, 8'($urandom), 8'($urandom), 16'($urandom), 1'b1);
      tick_n(4);
      settle();

      for (int phase = 0; phase < 3; phase++) begin
         random_setup();
         if (phase == 1) begin
            run_random(50);
            squeeze();
            run_random(40);
         end else begin
            run_random(110);
         end
         settle();
      end

      // Longest interval and hold: a few ticks must neither step nor release.
      req_idling = 1'b0;
      rsp_idling = 1'b0;
      program_regs(pick_angle(), pick_angle(), pick_offset(), 16'hFFFF);
      send(MODE_MOVE, (tracker.shoulder_now < HOME_ANGLE) ? MAX_ANGLE : 8'd0,
           (tracker.wrist_now < HOME_ANGLE) ? MAX_ANGLE : 8'd0, 16'hFFFF, 1'($urandom));
      send(MODE_GRIP, 8'($urandom), 8'($urandom), 16'($urandom), 1'($urandom));
      tick_n(8);
      settle();

      random_setup();
      run_random(90);
      req_ch.valid <= 1'b0;

      for (int n = 0; n < 4000 && tracker.expected_pulses.size() != 0; n++)
         @(posedge clock);
      repeat (16) @(posedge clock);
      if (tracker.expected_pulses.size() != 0) begin
         $display("%0d expected results never arrived", tracker.expected_pulses.size());
         tracker.mismatches += tracker.expected_pulses.size();
      end

      $display("Sent %0d items through %0d register writes; checked %0d pulse results.",
               tracker.items_seen, tracker.reg_writes, tracker.pulses_seen);
      $display("Input was held off for %0d cycles; %0d results were wrong or missing.",
               input_stalls, tracker.mismatches);
      if (tracker.mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/svgrip_pkg.sv
design/svgrip_if.sv
design/svgrip_serializer.sv
design/servo_slew_and_gripper_pulse.sv
tb/servo_pulse_check_pkg.sv
tb/testbench.sv
